[design/plid_pkg.sv]
`default_nettype none

package plid_pkg;

    // Field widths of the request and result items.
    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int LEN_FIELD_W  = 5;
    localparam int STATUS_W     = 2;

    // Default list capacity.
    localparam int CAPACITY_DEF = 16;

    // Command codes carried in the request tuser field.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // Shift command broadcast to every cell of the chain in the same cycle.
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } t_cmd;

endpackage

`default_nettype wire

[design/plid_cell.sv]
`default_nettype none

module plid_cell #(
    parameter int IDX = 0
) (
    input  wire logic                          i_clk,
    input  wire plid_pkg::t_cmd                i_cmd,
    input  wire logic [plid_pkg::DATA_W-1:0]   i_left,
    input  wire logic [plid_pkg::DATA_W-1:0]   i_right,
    output logic      [plid_pkg::DATA_W-1:0]   o_data,
    output logic      [plid_pkg::DATA_W-1:0]   o_tap
);
    import plid_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_hit;
    logic              w_after;

    assign w_hit   = (i_cmd.idx == MY_IDX);
    assign w_after = (MY_IDX > i_cmd.idx);

    // An insert opens a gap at the target and moves later entries one place
    // toward the tail; a delete pulls the target and later entries toward
    // the head.
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (w_after) begin
                n_data = i_left;
            end else if (w_hit) begin
                n_data = i_cmd.value;
            end
        end else if (i_cmd.del && (w_after || w_hit)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = w_hit ? r_data : '0;

endmodule

`default_nettype wire

[design/positional_list_insert_delete_unit.sv]
`default_nettype none

// Positional list unit. It keeps an ordered list of up to CAPACITY signed
// 32-bit values in a row of cells, one entry per cell. A request either
// inserts a value at a 1-based position (1 to length+1) or deletes the entry
// at a position (1 to length); every request produces exactly one result
// carrying a status, the inserted or removed value (zero on any error) and
// the list length after the request. A bad position gives status 1 and a
// valid insert into a full list gives status 2; in both cases the list is
// unchanged. The unit completes one request per clock cycle: every cell
// compares its own place with the target position and loads its left or
// right neighbor in the same cycle, and the removed value is gathered by an
// AND-OR select over all cells, which together set the cycle's logic depth.
// Results leave through an output register, so a new request is taken while
// a result waits, as long as the downstream side accepts it in that cycle.
// List contents are undefined after reset; only the length is cleared, and
// only entries below the length are ever returned.
module positional_list_insert_delete_unit #(
    parameter int CAPACITY = plid_pkg::CAPACITY_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request channel.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,   // [7:0] position, [39:8] value
    input  wire logic [0:0]  i_s_axis_tuser,   // [0] command (0 insert, 1 delete)
    // Result channel.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [39:0] o_m_axis_tdata,   // [31:0] result_value,
                                               // [36:32] list_length, rest zero
    output logic      [1:0]  o_m_axis_tuser    // [1:0] status
);
    import plid_pkg::*;

    // Length register holds 0..CAPACITY.
    localparam int LW   = $clog2(CAPACITY + 1);
    // Compare width for position against length + 1.
    localparam int CW   = POS_W + 1;
    localparam int LEXT = LW + LEN_FIELD_W;

    // Request fields.
    logic              w_cmd;
    logic [POS_W-1:0]  w_pos;
    logic [DATA_W-1:0] w_value;

    assign w_cmd   = i_s_axis_tuser[0];
    assign w_pos   = i_s_axis_tdata[POS_W-1:0];
    assign w_value = i_s_axis_tdata[POS_W +: DATA_W];

    // Handshake: the output register frees up whenever the result is taken.
    logic r_out_valid;
    logic w_acc;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // Length and request checking.
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic [CW-1:0] w_pos_c;
    logic [CW-1:0] w_len_c;
    logic          w_is_del;
    logic          w_bad;
    logic          w_full;
    t_status       w_status;

    assign w_is_del = (w_cmd == CMD_DELETE);
    assign w_pos_c  = CW'(w_pos);
    assign w_len_c  = CW'(r_len);
    assign w_full   = (r_len == LW'(CAPACITY));

    always_comb begin
        if (w_is_del) begin
            w_bad = (w_pos == '0) || (w_pos_c > w_len_c);
        end else begin
            w_bad = (w_pos == '0) || (w_pos_c > (w_len_c + CW'(1)));
        end
        if (w_bad) begin
            w_status = ST_BADPOS;
        end else if (!w_is_del && w_full) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_OK;
        end
    end

    // Command broadcast along the cell row; only successful requests shift.
    t_cmd w_cmd_bus;

    assign w_cmd_bus.ins   = w_acc && (w_status == ST_OK) && !w_is_del;
    assign w_cmd_bus.del   = w_acc && (w_status == ST_OK) && w_is_del;
    assign w_cmd_bus.idx   = w_pos - POS_W'(1);
    assign w_cmd_bus.value = w_value;

    always_comb begin
        n_len = r_len;
        if (w_cmd_bus.ins) begin
            n_len = r_len + LW'(1);
        end else if (w_cmd_bus.del) begin
            n_len = r_len - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    // Row of cells. Each cell sees its left and right neighbor; the head cell
    // never shifts right and the tail cell pulls in zero on delete.
    logic [DATA_W-1:0] w_data [CAPACITY];
    logic [DATA_W-1:0] w_tap  [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = w_value;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        plid_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd_bus),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_tap   (w_tap[g])
        );
    end

    // Only the target cell drives its tap, so an OR gathers the removed entry.
    logic [DATA_W-1:0] w_removed;

    always_comb begin
        w_removed = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_removed = w_removed | w_tap[k];
        end
    end

    // Result register.
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_value;
    logic [LEXT-1:0]   w_len_ext;

    assign w_len_ext = LEXT'(n_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    logic [LEN_FIELD_W-1:0] r_out_len;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_status <= w_status;
            r_out_len    <= w_len_ext[LEN_FIELD_W-1:0];
            if (w_status != ST_OK) begin
                r_out_value <= '0;
            end else if (w_is_del) begin
                r_out_value <= w_removed;
            end else begin
                r_out_value <= w_value;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {3'b000, r_out_len, r_out_value};

`ifndef SYNTHESIS
    // The length can never pass the capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_len) <= CW'(CAPACITY)))
        else $error("list length exceeds capacity");

    // A rejected request leaves the length alone and returns a zero value.
    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_status != ST_OK)) |=>
        ((r_len == $past(r_len)) && (r_out_value == '0)))
        else $error("rejected request changed the list or returned data");

    // A successful delete shrinks the list by exactly one entry.
    a_del_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_bus.del) |=> (r_len == ($past(r_len) - LW'(1))))
        else $error("delete did not shorten the list by one");

    // The result reports the length that the list holds after the request.
    a_len_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc) |=> (LEXT'(r_out_len) == (LEXT'(r_len) & LEXT'(5'h1f))))
        else $error("reported length disagrees with list length");
`endif

endmodule

`default_nettype wire
